### design/tfn_pkg.sv
// shared constants and types for the triangle face normal pipeline
package tfn_pkg;

  // coordinate and result formats
  localparam int CoordWidth = 32;
  localparam int NormFrac   = 14;
  localparam int OutW       = 16;

  // internal widths
  localparam int EdgeW   = CoordWidth + 1;
  localparam int ProdW   = 2 * EdgeW;
  localparam int CrossW  = ProdW + 1;
  localparam int ShW     = 31;
  localparam int SqW     = 2 * ShW;
  localparam int SumW    = 64;
  localparam int RootSteps = SumW / 2;
  localparam int LenW    = RootSteps;
  localparam int QuoW    = NormFrac + 1;
  localparam int NumW    = ShW + NormFrac + 1;
  localparam int ShAmtW  = $clog2(CrossW);

  // word widths on the ports
  localparam int InDataW  = 9 * CoordWidth;
  localparam int InBytesW = ((InDataW + 7) / 8) * 8;
  localparam int OutDataW = 3 * OutW;

  // per-item side data carried down the pipeline
  typedef struct packed {
    logic [2:0]          neg;
    logic                degen;
    logic [2:0][ShW-1:0] m;
  } item_meta_t;

  // square root step state
  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [SumW-1:0] root;
    item_meta_t      meta;
  } root_st_t;

  // division step state
  typedef struct packed {
    logic [2:0][NumW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
    logic [LenW-1:0]      len;
    logic [2:0]           neg;
    logic                 degen;
  } div_st_t;

endpackage

### design/triangle_face_normal.sv
// Triangle unit normal: fully pipelined edge, cross product, normalize and divide
//
// One triangle word enters per cycle and one normal word leaves per cycle once
// the pipe is full and the output side does not stall. There are eight front
// stages (edges, products, cross sum, magnitude, leading one search, shift,
// squares, sum of squares), one stage per result bit of the 32-bit integer
// square root, one stage to build the dividend, one stage per quotient bit of
// the three parallel restoring dividers, and the output register. A stall on
// the output side freezes every stage together, so nothing is lost or repeated.
// A zero cross product gives a zero normal with the degenerate flag set.
module triangle_face_normal
  import tfn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
  input  logic [InBytesW-1:0] s_axis_tdata,
  // flip_winding
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // normal_x, normal_y, normal_z from bit 0 up
  output logic [OutDataW-1:0] m_axis_tdata,
  // degenerate
  output logic                m_axis_tuser
);

  localparam int NStage = 8;

  logic ce;
  logic [NStage-1:0] vld_q;

  // global advance: move when the output slot is free or being taken
  assign ce = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ce;

  // stage 1: edges, swapped by the winding flag
  logic signed [2:0][EdgeW-1:0] ea_q, eb_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [EdgeW-1:0] p0, p1, p2, e1, e2;
        p0 = EdgeW'($signed(s_axis_tdata[CoordWidth*i +: CoordWidth]));
        p1 = EdgeW'($signed(s_axis_tdata[CoordWidth*(3+i) +: CoordWidth]));
        p2 = EdgeW'($signed(s_axis_tdata[CoordWidth*(6+i) +: CoordWidth]));
        e1 = p1 - p0;
        e2 = p2 - p0;
        ea_q[i] <= s_axis_tuser ? e2 : e1;
        eb_q[i] <= s_axis_tuser ? e1 : e2;
      end
    end
  end

  // stage 2: six products
  logic signed [5:0][ProdW-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      prod_q[0] <= $signed(ea_q[1]) * $signed(eb_q[2]);
      prod_q[1] <= $signed(ea_q[2]) * $signed(eb_q[1]);
      prod_q[2] <= $signed(ea_q[2]) * $signed(eb_q[0]);
      prod_q[3] <= $signed(ea_q[0]) * $signed(eb_q[2]);
      prod_q[4] <= $signed(ea_q[0]) * $signed(eb_q[1]);
      prod_q[5] <= $signed(ea_q[1]) * $signed(eb_q[0]);
    end
  end

  // stage 3: cross components
  logic signed [2:0][CrossW-1:0] cross_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        cross_q[i] <= CrossW'($signed(prod_q[2*i])) - CrossW'($signed(prod_q[2*i+1]));
      end
    end
  end

  // stage 4: magnitudes, signs and zero test
  logic [2:0][CrossW-1:0] mag_q;
  logic [2:0]             neg4_q;
  logic                   degen4_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        neg4_q[i] <= cross_q[i][CrossW-1];
        mag_q[i]  <= cross_q[i][CrossW-1] ? CrossW'(-cross_q[i]) : CrossW'(cross_q[i]);
      end
      degen4_q <= (cross_q[0] == '0) && (cross_q[1] == '0) && (cross_q[2] == '0);
    end
  end

  // stage 5: common right shift from the top set bit
  logic [CrossW-1:0]      ormag;
  logic [ShAmtW-1:0]      shamt_d, shamt_q;
  logic [2:0][CrossW-1:0] mag5_q;
  logic [2:0]             neg5_q;
  logic                   degen5_q;
  always_comb begin
    ormag   = mag_q[0] | mag_q[1] | mag_q[2];
    shamt_d = '0;
    for (int b = ShW; b < CrossW; b++) begin
      if (ormag[b]) shamt_d = ShAmtW'(b - ShW + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      shamt_q  <= shamt_d;
      mag5_q   <= mag_q;
      neg5_q   <= neg4_q;
      degen5_q <= degen4_q;
    end
  end

  // stage 6: shift into 31 bits
  item_meta_t meta6_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        meta6_q.m[i] <= ShW'(mag5_q[i] >> shamt_q);
      end
      meta6_q.neg   <= neg5_q;
      meta6_q.degen <= degen5_q;
    end
  end

  // stage 7: squares
  logic [2:0][SqW-1:0] sq_q;
  item_meta_t          meta7_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= meta6_q.m[i] * meta6_q.m[i];
      end
      meta7_q <= meta6_q;
    end
  end

  // stage 8: sum of squares enters the root pipe
  root_st_t rt_q [RootSteps+1];
  always_ff @(posedge clk_i) begin
    if (ce) begin
      rt_q[0].rem  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      rt_q[0].root <= '0;
      rt_q[0].meta <= meta7_q;
    end
  end

  // square root: one result bit per stage
  logic [RootSteps-1:0] rvld_q;
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam logic [SumW-1:0] RBit = SumW'(1) << (SumW - 2 - 2 * k);
    always_ff @(posedge clk_i) begin
      if (ce) begin
        if (rt_q[k].rem >= rt_q[k].root + RBit) begin
          rt_q[k+1].rem  <= rt_q[k].rem - (rt_q[k].root + RBit);
          rt_q[k+1].root <= (rt_q[k].root >> 1) + RBit;
        end else begin
          rt_q[k+1].rem  <= rt_q[k].rem;
          rt_q[k+1].root <= rt_q[k].root >> 1;
        end
        rt_q[k+1].meta <= rt_q[k].meta;
      end
    end
  end

  // dividend: scaled magnitude plus half the length
  div_st_t dv_q [QuoW+1];
  logic [LenW-1:0] len_c;
  assign len_c = (rt_q[RootSteps].root[LenW-1:0] == '0) ? LenW'(1)
                                                         : rt_q[RootSteps].root[LenW-1:0];
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[0].rem[i] <= NumW'({rt_q[RootSteps].meta.m[i], NormFrac'(0)})
                          + NumW'(len_c >> 1);
        dv_q[0].quo[i] <= '0;
      end
      dv_q[0].len   <= len_c;
      dv_q[0].neg   <= rt_q[RootSteps].meta.neg;
      dv_q[0].degen <= rt_q[RootSteps].meta.degen;
    end
  end

  // restoring division: one quotient bit per stage, three lanes
  logic [QuoW:0] dvld_q;
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int Sh = QuoW - 1 - k;
    always_ff @(posedge clk_i) begin
      if (ce) begin
        for (int i = 0; i < 3; i++) begin
          logic [NumW:0] dsh;
          dsh = (NumW+1)'(dv_q[k].len) << Sh;
          if ((NumW+1)'(dv_q[k].rem[i]) >= dsh) begin
            dv_q[k+1].rem[i] <= dv_q[k].rem[i] - dsh[NumW-1:0];
            dv_q[k+1].quo[i] <= dv_q[k].quo[i] | (QuoW'(1) << Sh);
          end else begin
            dv_q[k+1].rem[i] <= dv_q[k].rem[i];
            dv_q[k+1].quo[i] <= dv_q[k].quo[i];
          end
        end
        dv_q[k+1].len   <= dv_q[k].len;
        dv_q[k+1].neg   <= dv_q[k].neg;
        dv_q[k+1].degen <= dv_q[k].degen;
      end
    end
  end

  // output register: apply sign, force zero on degenerate
  logic [OutDataW-1:0] odata_q;
  logic                odeg_q;
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        logic [OutW-1:0] mg;
        mg = OutW'(dv_q[QuoW].quo[i]);
        if (dv_q[QuoW].degen) odata_q[OutW*i +: OutW] <= '0;
        else odata_q[OutW*i +: OutW] <= dv_q[QuoW].neg[i] ? OutW'(-mg) : mg;
      end
      odeg_q <= dv_q[QuoW].degen;
    end
  end

  // valid bits for every stage
  logic oval_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= '0;
      dvld_q <= '0;
      oval_q <= 1'b0;
    end else if (ce) begin
      vld_q  <= {vld_q[NStage-2:0], s_axis_tvalid};
      rvld_q <= {rvld_q[RootSteps-2:0], vld_q[NStage-1]};
      dvld_q <= {dvld_q[QuoW-1:0], rvld_q[RootSteps-1]};
      oval_q <= dvld_q[QuoW];
    end
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = odeg_q;

endmodule

### tb/triangle_face_normal_tb.sv
// testbench for the triangle face normal pipeline: random and directed triangles
`timescale 1ns / 1ps

module triangle_face_normal_tb
  import tfn_pkg::*;
();

  typedef struct {
    logic [31:0] crd [9];
    logic        flip;
  } tri_word_t;

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InBytesW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  tri_word_t    pending_tris [$];
  normal_word_t expected_normals [$];
  int  n_errors = 0;
  bit  stim_done = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  hold_off = 1'b0;

  triangle_face_normal DUT (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // exact isqrt of a 64-bit value
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit normal of one triangle, exact fixed point
  function automatic normal_word_t unit_normal(tri_word_t t);
    normal_word_t res;
    logic signed [33:0]  e1 [3];
    logic signed [33:0]  e2 [3];
    logic signed [33:0]  a [3];
    logic signed [33:0]  b [3];
    logic signed [71:0]  cr [3];
    logic [71:0]         mg [3];
    logic [63:0]         m [3];
    logic [63:0]         sum;
    logic [63:0]         len;
    logic [63:0]         q;
    int i;
    for (i = 0; i < 3; i++) begin
      e1[i] = $signed(t.crd[3+i]) - $signed(t.crd[i]);
      e2[i] = $signed(t.crd[6+i]) - $signed(t.crd[i]);
      a[i] = t.flip ? e2[i] : e1[i];
      b[i] = t.flip ? e1[i] : e2[i];
    end
    cr[0] = a[1] * b[2] - a[2] * b[1];
    cr[1] = a[2] * b[0] - a[0] * b[2];
    cr[2] = a[0] * b[1] - a[1] * b[0];
    res = '{16'd0, 16'd0, 16'd0, 1'b1};
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) return res;
    for (i = 0; i < 3; i++) mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
    while ((mg[0] | mg[1] | mg[2]) >= (72'd1 << 31))
      for (i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
    sum = 0;
    for (i = 0; i < 3; i++) begin
      m[i] = mg[i][63:0];
      sum = sum + m[i] * m[i];
    end
    len = floor_sqrt(sum);
    if (len == 0) len = 1;
    res.degen = 1'b0;
    for (i = 0; i < 3; i++) begin
      q = ((m[i] << NormFrac) + (len >> 1)) / len;
      if (cr[i] < 0) q = -q;
      if (i == 0) res.nx = q[15:0];
      else if (i == 1) res.ny = q[15:0];
      else res.nz = q[15:0];
    end
    return res;
  endfunction

  // random coordinate: full range, small values, or extremes
  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return $urandom_range(0, 2000) - 1000;
    return r == 8 ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          tri_word_t t;
          t = pending_tris.pop_front();
          expected_normals.push_back(unit_normal(t));
          for (int i = 0; i < 9; i++) s_axis_tdata[i*32 +: 32] <= t.crd[i];
          s_axis_tuser <= t.flip;
          s_axis_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // receiver ready with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_normals.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected normal word %h", m_axis_tdata);
      end else begin
        normal_word_t e;
        e = expected_normals.pop_front();
        if (m_axis_tdata !== {e.nz, e.ny, e.nx} || m_axis_tuser !== e.degen) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp %h/%b got %h/%b", {e.nz, e.ny, e.nx}, e.degen,
                     m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  function automatic tri_word_t make_tri(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                         logic [31:0] c3, logic [31:0] c4, logic [31:0] c5,
                                         logic [31:0] c6, logic [31:0] c7, logic [31:0] c8,
                                         logic f);
    tri_word_t t;
    t.crd = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    t.flip = f;
    return t;
  endfunction

  // stimulus
  initial begin
    tri_word_t t;
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    // directed: unit axes, both windings, degenerate, extremes
    pending_tris.push_back(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 1'b0));
    pending_tris.push_back(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 1'b1));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 1'b0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 1'b1));
    pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 1'b0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 1'b1));
    pending_tris.push_back(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 1'b0));
    pending_tris.push_back(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx, 1'b1));
    pending_tris.push_back(make_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn, 1'b0));
    pending_tris.push_back(make_tri(mx, mn, mx, mn, mx, mn, mn, mn, mx, 1'b1));
    pending_tris.push_back(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1'b0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 1, 32'hffffffff, 1, 0, 1'b1));
    pending_tris.push_back(make_tri(0, 0, 0, mx, 1, 0, 1, mx, 0, 1'b0));
    // random, some degenerate
    for (int n = 0; n < 1900; n++) begin
      for (int i = 0; i < 9; i++) t.crd[i] = rand_coord();
      t.flip = $urandom_range(0, 1);
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 3; i++) t.crd[6+i] = t.crd[3+i];
      pending_tris.push_back(t);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_tris.size() == 0 && !(s_axis_tvalid && !s_axis_tready));
    @(posedge clk_i);
    wait (expected_normals.size() == 0);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && expected_normals.size() == 0) begin
      $display("PASS triangle_face_normal");
    end else begin
      $display("FAIL triangle_face_normal");
    end
    $finish;
  end

  // timeout
  initial begin
    #20000000;
    $display("FAIL triangle_face_normal");
    $finish;
  end

endmodule

### files.f
design/tfn_pkg.sv
design/triangle_face_normal.sv
tb/triangle_face_normal_tb.sv
